/* hw/rtl/md5_pkg.sv */
// Shared types, constants and round tables for the MD5 stream hasher.
package md5_pkg;

    // MD5 initial chaining words A, B, C, D
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Word slot in a block where the 64-bit length starts (byte 56)
    localparam logic [3:0] LEN_WORD_IDX = 4'd14;
    localparam logic [3:0] LAST_WORD_IDX = 4'd15;

    // Default depth of the word queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // One 32-bit message word on its way to the compression engine
    typedef struct packed {
        logic [31:0] word;
        logic        blk_end;   // last word of a 64-byte block
        logic        msg_end;   // last word of the final padded block
    } t_qword;

    typedef enum logic [2:0] {
        F_IN,
        F_PAD_FIRST,
        F_PAD_ZERO,
        F_LEN_LO,
        F_LEN_HI
    } t_front_state;

    typedef enum logic [1:0] {
        B_LOAD,
        B_ROUND,
        B_ADD,
        B_OUT
    } t_back_state;

    // Message word index used by a round
    function automatic logic [3:0] msg_idx(input logic [5:0] r);
        logic [3:0] rl;
        logic [3:0] res;
        rl = r[3:0];
        case (r[5:4])
            2'd0:    res = rl;
            2'd1:    res = rl * 4'd5 + 4'd1;
            2'd2:    res = rl * 4'd3 + 4'd5;
            default: res = rl * 4'd7;
        endcase
        return res;
    endfunction

    // Left-rotate amount of a round
    function automatic logic [4:0] rot_amt(input logic [5:0] r);
        logic [4:0] res;
        case ({r[5:4], r[1:0]})
            4'd0:    res = 5'd7;
            4'd1:    res = 5'd12;
            4'd2:    res = 5'd17;
            4'd3:    res = 5'd22;
            4'd4:    res = 5'd5;
            4'd5:    res = 5'd9;
            4'd6:    res = 5'd14;
            4'd7:    res = 5'd20;
            4'd8:    res = 5'd4;
            4'd9:    res = 5'd11;
            4'd10:   res = 5'd16;
            4'd11:   res = 5'd23;
            4'd12:   res = 5'd6;
            4'd13:   res = 5'd10;
            4'd14:   res = 5'd15;
            default: res = 5'd21;
        endcase
        return res;
    endfunction

    // Additive constant of a round
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] res;
        case (r)
            6'd0:  res = 32'hd76aa478;  6'd1:  res = 32'he8c7b756;
            6'd2:  res = 32'h242070db;  6'd3:  res = 32'hc1bdceee;
            6'd4:  res = 32'hf57c0faf;  6'd5:  res = 32'h4787c62a;
            6'd6:  res = 32'ha8304613;  6'd7:  res = 32'hfd469501;
            6'd8:  res = 32'h698098d8;  6'd9:  res = 32'h8b44f7af;
            6'd10: res = 32'hffff5bb1;  6'd11: res = 32'h895cd7be;
            6'd12: res = 32'h6b901122;  6'd13: res = 32'hfd987193;
            6'd14: res = 32'ha679438e;  6'd15: res = 32'h49b40821;
            6'd16: res = 32'hf61e2562;  6'd17: res = 32'hc040b340;
            6'd18: res = 32'h265e5a51;  6'd19: res = 32'he9b6c7aa;
            6'd20: res = 32'hd62f105d;  6'd21: res = 32'h02441453;
            6'd22: res = 32'hd8a1e681;  6'd23: res = 32'he7d3fbc8;
            6'd24: res = 32'h21e1cde6;  6'd25: res = 32'hc33707d6;
            6'd26: res = 32'hf4d50d87;  6'd27: res = 32'h455a14ed;
            6'd28: res = 32'ha9e3e905;  6'd29: res = 32'hfcefa3f8;
            6'd30: res = 32'h676f02d9;  6'd31: res = 32'h8d2a4c8a;
            6'd32: res = 32'hfffa3942;  6'd33: res = 32'h8771f681;
            6'd34: res = 32'h6d9d6122;  6'd35: res = 32'hfde5380c;
            6'd36: res = 32'ha4beea44;  6'd37: res = 32'h4bdecfa9;
            6'd38: res = 32'hf6bb4b60;  6'd39: res = 32'hbebfbc70;
            6'd40: res = 32'h289b7ec6;  6'd41: res = 32'heaa127fa;
            6'd42: res = 32'hd4ef3085;  6'd43: res = 32'h04881d05;
            6'd44: res = 32'hd9d4d039;  6'd45: res = 32'he6db99e5;
            6'd46: res = 32'h1fa27cf8;  6'd47: res = 32'hc4ac5665;
            6'd48: res = 32'hf4292244;  6'd49: res = 32'h432aff97;
            6'd50: res = 32'hab9423a7;  6'd51: res = 32'hfc93a039;
            6'd52: res = 32'h655b59c3;  6'd53: res = 32'h8f0ccc92;
            6'd54: res = 32'hffeff47d;  6'd55: res = 32'h85845dd1;
            6'd56: res = 32'h6fa87e4f;  6'd57: res = 32'hfe2ce6e0;
            6'd58: res = 32'ha3014314;  6'd59: res = 32'h4e0811a1;
            6'd60: res = 32'hf7537e82;  6'd61: res = 32'hbd3af235;
            6'd62: res = 32'h2ad7d2bb;  default: res = 32'heb86d391;
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/md5_front.sv */
// Byte packer and padding generator: turns message bytes into block words.
module md5_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_has_byte,
    input  logic            i_eom,
    output logic            o_push_valid,
    output md5_pkg::t_qword o_push_data,
    input  logic            i_push_ready
);
    import md5_pkg::*;

    t_front_state r_state, n_state;
    logic [5:0]   r_fill, n_fill;
    logic [60:0]  r_total, n_total;
    logic [31:0]  r_word, n_word;

    logic [1:0]  lane;
    logic [3:0]  wi;
    logic [3:0]  wi_next;
    logic [31:0] pad_word;
    logic        accept;

    assign lane    = r_fill[1:0];
    assign wi      = r_fill[5:2];
    assign wi_next = wi + 4'd1;

    // Build the word that carries the 0x80 marker after the held bytes
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            if (2'(l) < lane) begin
                pad_word[8*l +: 8] = r_word[8*l +: 8];
            end else if (2'(l) == lane) begin
                pad_word[8*l +: 8] = PAD_BYTE;
            end else begin
                pad_word[8*l +: 8] = 8'h00;
            end
        end
    end

    assign accept = i_valid && o_ready;

    // Next state, byte packing and padding sequence
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_total      = r_total;
        n_word       = r_word;
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        o_push_data  = '{word: 32'h0, blk_end: 1'b0, msg_end: 1'b0};
        case (r_state)
            F_IN: begin
                o_ready = i_push_ready;
                if (accept && i_has_byte) begin
                    n_word[{lane, 3'b000} +: 8] = i_data_byte;
                    n_fill  = r_fill + 6'd1;
                    n_total = r_total + 61'd1;
                    if (lane == 2'd3) begin
                        o_push_valid        = 1'b1;
                        o_push_data.word    = {i_data_byte, r_word[23:0]};
                        o_push_data.blk_end = (wi == LAST_WORD_IDX);
                    end
                end
                if (accept && i_eom) begin
                    n_state = F_PAD_FIRST;
                end
            end
            F_PAD_FIRST: begin
                o_push_valid        = 1'b1;
                o_push_data.word    = pad_word;
                o_push_data.blk_end = (wi == LAST_WORD_IDX);
                if (i_push_ready) begin
                    n_fill  = {wi_next, 2'b00};
                    n_state = (wi_next == LEN_WORD_IDX) ? F_LEN_LO : F_PAD_ZERO;
                end
            end
            F_PAD_ZERO: begin
                o_push_valid        = 1'b1;
                o_push_data.blk_end = (wi == LAST_WORD_IDX);
                if (i_push_ready) begin
                    n_fill = {wi_next, 2'b00};
                    if (wi_next == LEN_WORD_IDX) begin
                        n_state = F_LEN_LO;
                    end
                end
            end
            F_LEN_LO: begin
                o_push_valid     = 1'b1;
                o_push_data.word = {r_total[28:0], 3'b000};
                if (i_push_ready) begin
                    n_fill  = {wi_next, 2'b00};
                    n_state = F_LEN_HI;
                end
            end
            F_LEN_HI: begin
                o_push_valid        = 1'b1;
                o_push_data.word    = r_total[60:29];
                o_push_data.blk_end = 1'b1;
                o_push_data.msg_end = 1'b1;
                if (i_push_ready) begin
                    n_fill  = 6'd0;
                    n_total = 61'd0;
                    n_state = F_IN;
                end
            end
            default: begin
                n_state = F_IN;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IN;
            r_fill  <= 6'd0;
            r_total <= 61'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    // Hold partial word
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

/* hw/rtl/md5_queue.sv */
// Small word queue between the byte packer and the compression engine.
module md5_queue #(
    parameter int DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  md5_pkg::t_qword i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output md5_pkg::t_qword o_pop_data
);
    import md5_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qword        r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

/* hw/rtl/md5_back.sv */
// MD5 compression engine: loads block words, runs 64 rounds, emits the digest.
module md5_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  md5_pkg::t_qword i_pop_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_digest_word,
    output logic [1:0]      o_word_index,
    output logic            o_last_word
);
    import md5_pkg::*;

    t_back_state r_state, n_state;
    logic [31:0] r_w [16];
    logic [3:0]  r_wi, n_wi;
    logic [5:0]  r_round, n_round;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic        r_msg_end, n_msg_end;
    logic [1:0]  r_oi, n_oi;
    logic        load_word;

    logic [31:0] mix;
    logic [31:0] t_sum;
    logic [63:0] rot_dbl;
    logic [31:0] b_new;

    // One MD5 round on the working registers
    always_comb begin
        case (r_round[5:4])
            2'd0:    mix = (r_b & r_c) | (~r_b & r_d);
            2'd1:    mix = (r_d & r_b) | (~r_d & r_c);
            2'd2:    mix = r_b ^ r_c ^ r_d;
            default: mix = r_c ^ (r_b | ~r_d);
        endcase
        t_sum   = mix + r_a + round_k(r_round) + r_w[msg_idx(r_round)];
        rot_dbl = {t_sum, t_sum} << rot_amt(r_round);
        b_new   = r_b + rot_dbl[63:32];
    end

    assign o_digest_word = r_chain[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 2'd3);

    // Next state and sequencing
    always_comb begin
        n_state   = r_state;
        n_wi      = r_wi;
        n_round   = r_round;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_chain   = r_chain;
        n_msg_end = r_msg_end;
        n_oi      = r_oi;
        o_pop_ready = 1'b0;
        o_out_valid = 1'b0;
        load_word   = 1'b0;
        case (r_state)
            B_LOAD: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    load_word = 1'b1;
                    n_wi      = r_wi + 4'd1;
                    if (i_pop_data.blk_end) begin
                        n_msg_end = i_pop_data.msg_end;
                        n_wi      = 4'd0;
                        n_round   = 6'd0;
                        n_a       = r_chain[0];
                        n_b       = r_chain[1];
                        n_c       = r_chain[2];
                        n_d       = r_chain[3];
                        n_state   = B_ROUND;
                    end
                end
            end
            B_ROUND: begin
                n_a     = r_d;
                n_d     = r_c;
                n_c     = r_b;
                n_b     = b_new;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = B_ADD;
                end
            end
            B_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                n_oi       = 2'd0;
                n_state    = r_msg_end ? B_OUT : B_LOAD;
            end
            B_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_oi = r_oi + 2'd1;
                    if (r_oi == 2'd3) begin
                        n_chain[0] = IV_A;
                        n_chain[1] = IV_B;
                        n_chain[2] = IV_C;
                        n_chain[3] = IV_D;
                        n_state    = B_LOAD;
                    end
                end
            end
            default: begin
                n_state = B_LOAD;
            end
        endcase
    end

    // Hold control state and chaining words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_LOAD;
            r_wi       <= 4'd0;
            r_round    <= 6'd0;
            r_msg_end  <= 1'b0;
            r_oi       <= 2'd0;
            r_chain[0] <= IV_A;
            r_chain[1] <= IV_B;
            r_chain[2] <= IV_C;
            r_chain[3] <= IV_D;
        end else begin
            r_state   <= n_state;
            r_wi      <= n_wi;
            r_round   <= n_round;
            r_msg_end <= n_msg_end;
            r_oi      <= n_oi;
            r_chain   <= n_chain;
        end
    end

    // Hold working registers and block words
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_c <= n_c;
        r_d <= n_d;
        if (load_word) begin
            r_w[r_wi] <= i_pop_data.word;
        end
    end

endmodule

/* hw/rtl/md5_stream_hasher.sv */
// Top level of the byte-stream MD5 hasher.
//
// Send the message one byte per item on the slave stream (tuser = 1 when
// tdata carries a byte) and mark its final item with tlast; a final item
// without a byte is allowed, which also hashes an empty message. Bytes are
// taken one per cycle while the word queue has room and no padding is being
// written. Each 64-byte block takes the loading of its words into the engine,
// the 64 rounds and the chaining add; the loading cannot overlap the rounds
// since both use the single block buffer. The default word queue holds
// four words. After the final item the front writes the padding and length
// words (filling out the last block, plus one more block when the length
// does not fit), then the digest leaves as four items, words A to D, each
// read low byte first, tlast on D. The next message may follow at once.
module md5_stream_hasher #(
    parameter int QUEUE_DEPTH = md5_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [1:0]  m_axis_tuser,   // [1:0] word_index
    output logic        m_axis_tlast    // last_word
);
    import md5_pkg::*;

    logic   push_valid;
    logic   push_ready;
    t_qword push_data;
    logic   pop_valid;
    logic   pop_ready;
    t_qword pop_data;

    md5_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data_byte  (s_axis_tdata),
        .i_has_byte   (s_axis_tuser[0]),
        .i_eom        (s_axis_tlast),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    md5_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    md5_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_data    (pop_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_digest_word (m_axis_tdata),
        .o_word_index  (m_axis_tuser),
        .o_last_word   (m_axis_tlast)
    );

endmodule

/* dv/md5_digest_checker.sv */
// Checker for the MD5 stream hasher: predicts each digest and compares the output items.
`timescale 1ns / 100ps

module md5_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] has_byte
    input  logic        i_s_tlast,   // end_of_message
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] digest_word
    input  logic [1:0]  i_m_tuser,   // [1:0] word_index
    input  logic        i_m_tlast,   // last_word
    output int          o_err_count,
    output int          o_pending
);

    import md5_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  index;
        logic        last;
    } t_digest_word;

    // Words of the digests still on their way out of the block
    t_digest_word digest_q[$];

    // Own copy of the hashing state
    logic [31:0] chain_r [4];
    logic [7:0]  blk_r [64];
    int unsigned fill_r;
    logic [60:0] msg_len_r;

    // Per-round additive constants and rotate amounts
    logic [31:0] sine_tab [64];
    logic [4:0]  rot_tab [16];

    initial begin
        sine_tab = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
        };
        rot_tab = '{
            5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
        };
    end

    // Start a new message from the initial chaining words
    function automatic void restart_message();
        chain_r[0] = IV_A;
        chain_r[1] = IV_B;
        chain_r[2] = IV_C;
        chain_r[3] = IV_D;
        for (int i = 0; i < 64; i++) begin
            blk_r[i] = 8'h00;
        end
        fill_r    = 0;
        msg_len_r = '0;
    endfunction

    // Run the 64 rounds over the held block and fold into the chaining words
    function automatic void md5_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, mix, t;
        int          g;
        int          sh;
        for (int r = 0; r < 16; r++) begin
            w[r] = {blk_r[4*r+3], blk_r[4*r+2], blk_r[4*r+1], blk_r[4*r]};
        end
        a = chain_r[0];
        b = chain_r[1];
        c = chain_r[2];
        d = chain_r[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin
                    mix = (b & c) | (~b & d);
                    g   = r;
                end
                1: begin
                    mix = (d & b) | (~d & c);
                    g   = (5 * r + 1) % 16;
                end
                2: begin
                    mix = b ^ c ^ d;
                    g   = (3 * r + 5) % 16;
                end
                default: begin
                    mix = c ^ (b | ~d);
                    g   = (7 * r) % 16;
                end
            endcase
            t  = mix + a + sine_tab[r] + w[g];
            sh = rot_tab[(r / 16) * 4 + r % 4];
            a  = d;
            d  = c;
            c  = b;
            b  = b + ((t << sh) | (t >> (32 - sh)));
        end
        chain_r[0] = chain_r[0] + a;
        chain_r[1] = chain_r[1] + b;
        chain_r[2] = chain_r[2] + c;
        chain_r[3] = chain_r[3] + d;
    endfunction

    // Take one accepted item; on the end of a message pad and queue the digest
    function automatic void absorb_item(input logic [7:0] b, input logic hb, input logic eom);
        int           pos;
        logic [63:0]  bit_len;
        t_digest_word dw;
        if (hb) begin
            blk_r[fill_r] = b;
            fill_r        = fill_r + 1;
            msg_len_r     = msg_len_r + 61'd1;
            if (fill_r == 64) begin
                md5_compress();
                fill_r = 0;
            end
        end
        if (!eom) begin
            return;
        end
        // Pad with the marker byte, zeros and the bit length
        pos        = fill_r;
        blk_r[pos] = PAD_BYTE;
        pos        = pos + 1;
        if (pos > 56) begin
            while (pos < 64) begin
                blk_r[pos] = 8'h00;
                pos        = pos + 1;
            end
            md5_compress();
            pos = 0;
        end
        while (pos < 56) begin
            blk_r[pos] = 8'h00;
            pos        = pos + 1;
        end
        bit_len = {msg_len_r, 3'b000};
        for (int k = 0; k < 8; k++) begin
            blk_r[56+k] = bit_len[8*k +: 8];
        end
        md5_compress();
        for (int k = 0; k < 4; k++) begin
            dw.word  = chain_r[k];
            dw.index = k[1:0];
            dw.last  = (k == 3);
            digest_q.push_back(dw);
        end
        restart_message();
    endfunction

    // Track accepted items on both channels
    always @(posedge i_clk) begin
        t_digest_word dw;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
            o_err_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                absorb_item(i_s_tdata, i_s_tuser[0], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (digest_q.size() == 0) begin
                    $display("%0t: unexpected digest word: actual %h idx %0d last %b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                    o_err_count = o_err_count + 1;
                end else begin
                    dw = digest_q.pop_front();
                    if (dw.word !== i_m_tdata || dw.index !== i_m_tuser
                        || dw.last !== i_m_tlast) begin
                        $display("%0t: mismatch: exp %h/%0d/%b act %h/%0d/%b",
                                 $time, dw.word, dw.index, dw.last,
                                 i_m_tdata, i_m_tuser, i_m_tlast);
                        o_err_count = o_err_count + 1;
                    end
                end
            end
        end
        o_pending = digest_q.size();
    end

endmodule

/* dv/md5_stream_hasher_test.sv */
// Top of the MD5 stream hasher testbench: clock, reset, byte traffic and verdict.
`timescale 1ns / 100ps

module md5_stream_hasher_test;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] has_byte
    logic        s_axis_tlast;   // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [1:0]  m_axis_tuser;   // [1:0] word_index
    logic        m_axis_tlast;   // last_word

    int err_count;
    int pending_words;
    int phase_sel;
    int items_sent;

    md5_stream_hasher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    md5_digest_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tlast   (s_axis_tlast),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .i_m_tlast   (m_axis_tlast),
        .o_err_count (err_count),
        .o_pending   (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #1000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Drain digest words; hold off once for a long stretch when the last phase starts
    initial begin : digest_sink
        int  hold_left;
        bit  held_once;
        hold_left = 0;
        held_once = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (phase_sel == 2 && !held_once) begin
                held_once = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >=
                                  ((phase_sel == 0) ? 48 : (phase_sel == 1) ? 33 : 0));
            end
        end
    end

    // Offer one item after a random idle gap and hold it until accepted
    task automatic push_item(input logic [7:0] b, input logic hb, input logic eom);
        while ($urandom_range(99) < ((phase_sel == 0) ? 33 : (phase_sel == 1) ? 48 : 0)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= hb;
        s_axis_tlast  <= eom;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (hb || eom) begin
            items_sent = items_sent + 1;
        end
    endtask

    // Send one message of random content, with stray byteless items mixed in
    task automatic send_message(input int limit);
        int n;
        bit byte_on_last;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: n = $urandom_range(0, 12);
            6:                n = $urandom_range(13, 54);
            default: begin
                // lengths around the padding and block boundaries
                case ($urandom_range(9))
                    0:       n = 55;
                    1:       n = 56;
                    2:       n = 57;
                    3:       n = 63;
                    4:       n = 64;
                    5:       n = 65;
                    6:       n = 119;
                    7:       n = 120;
                    8:       n = 127;
                    default: n = 128;
                endcase
            end
        endcase
        // keep the message inside what is left of the phase
        if (n > limit) begin
            n = limit;
        end
        byte_on_last = (n > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                push_item(8'($urandom), 1'b0, 1'b0);
            end
            push_item(8'($urandom), 1'b1, byte_on_last && (i == n - 1));
        end
        if (!byte_on_last) begin
            push_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Run random messages until the phase has used up its item budget
    task automatic run_traffic_phase(input int budget);
        int start_items;
        start_items = items_sent;
        while (items_sent - start_items < budget) begin
            send_message(budget - (items_sent - start_items));
        end
    endtask

    initial begin
        phase_sel  = 0;
        items_sent = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty message, with junk on the unused data byte
        push_item(8'ha5, 1'b0, 1'b1);
        // Stray item, then a single zero byte carried on the last item
        push_item(8'hff, 1'b0, 1'b0);
        push_item(8'h00, 1'b1, 1'b1);
        // Single all-ones byte on the last item
        push_item(8'hff, 1'b1, 1'b1);
        // "abc" with a stray item inside and a byteless last item
        push_item(8'h61, 1'b1, 1'b0);
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h62, 1'b1, 1'b0);
        push_item(8'h63, 1'b1, 1'b0);
        push_item(8'h5a, 1'b0, 1'b1);
        // Stray item before another empty message
        push_item(8'h00, 1'b0, 1'b0);
        push_item(8'h00, 1'b0, 1'b1);
        // Bytes next to the pad marker value
        push_item(8'h01, 1'b1, 1'b0);
        push_item(8'h7f, 1'b1, 1'b0);
        push_item(8'h80, 1'b1, 1'b1);
        // No room left for the length: padding spills into a second block
        for (int i = 0; i < 56; i++) begin
            push_item(8'(i * 7), 1'b1, 1'b0);
        end
        push_item(8'h00, 1'b0, 1'b1);

        run_traffic_phase(20);
        phase_sel = 1;
        run_traffic_phase(20);
        phase_sel = 2;
        run_traffic_phase(20);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // Wait for every digest, then watch for strays
        while (pending_words != 0) begin
            @(posedge i_clk);
        end
        repeat (400) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/md5_pkg.sv
hw/rtl/md5_front.sv
hw/rtl/md5_queue.sv
hw/rtl/md5_back.sv
hw/rtl/md5_stream_hasher.sv
dv/md5_digest_checker.sv
dv/md5_stream_hasher_test.sv
